/* design/gcws_pkg.sv */
// Shared types and constants for the two-controller GLCD write sequencer.
`default_nettype none

package gcws_pkg;

  // Input item opcodes
  typedef enum logic [1:0] {
    OP_DATA = 2'd0,
    OP_CMD  = 2'd1,
    OP_GOTO = 2'd2,
    OP_RSVD = 2'd3
  } opcode_t;

  // Configuration register indexes
  typedef enum logic {
    REG_PAGE_BASE = 1'b0,
    REG_COL_BASE  = 1'b1
  } cfg_reg_t;

  // Chip select codes: bit 0 left half, bit 1 right half
  localparam logic [1:0] SEL_LEFT  = 2'b01;
  localparam logic [1:0] SEL_RIGHT = 2'b10;
  localparam logic [1:0] SEL_BOTH  = 2'b11;

  localparam logic [7:0] PAGE_LIMIT = 8'd7;
  localparam logic [7:0] COL_LIMIT  = 8'd127;
  localparam logic [2:0] PAGE_MAX   = 3'd7;
  localparam logic [6:0] COL_LAST   = 7'd127;
  localparam logic [6:0] COL_HALF   = 7'd64;

  // Most bus writes one item can produce
  localparam int MAX_WRITES = 3;

  typedef struct packed {
    logic [7:0] page_base;
    logic [7:0] col_base;
  } cfg_t;

  typedef struct packed {
    logic [1:0] sel;
    logic       is_data;
    logic [7:0] bus_byte;
  } bus_write_t;

  // One queued job: 1 to 3 bus writes, issued from wr[0] upward
  typedef struct packed {
    logic [1:0]                        count;
    bus_write_t [MAX_WRITES-1:0]       wr;
  } job_t;

  function automatic bus_write_t mk_write(logic [1:0] sel, logic is_data,
                                          logic [7:0] bus_byte);
    bus_write_t w;
    w.sel      = sel;
    w.is_data  = is_data;
    w.bus_byte = bus_byte;
    return w;
  endfunction

endpackage

`default_nettype wire

/* design/dual_controller_glcd_write_sequencer.sv */
// Top level of the write sequencer for a 128x64 panel built from two 64-column controllers.
//
// Turns data, command and goto transactions into bus writes for a panel whose left
// controller holds columns 0..63 and right controller columns 64..127, and keeps the
// cursor (page 0..7, column 0..127). A goto clamps and stores the cursor and emits a
// set-page and a set-column write to the owning half; a command goes out unchanged; a
// data write goes out and advances the cursor, with an address re-send to the right
// half when a single-half write enters column 64 and to the left half after wrapping past
// column 127. Each input transaction yields one, two or three output transactions;
// out_last marks the final one. Opcode 3 is taken and dropped. Rate: the output side
// issues one bus write per cycle while out_stall is low; the front end takes a new item
// every cycle as long as the job queue (QUEUE_DEPTH entries) has room, and opcode 3
// takes no slot. With an empty queue, a taken item is first written into the queue and
// then loaded into the output register, which raises out_valid. Configuration writes
// (cfg_we) are expected only while the block is idle.
`default_nettype none

module dual_controller_glcd_write_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  // input transactions
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_opcode,
  input  wire logic [7:0] in_value,
  input  wire logic [1:0] in_target,
  input  wire logic [7:0] in_page,
  input  wire logic [7:0] in_column,
  // output transactions, one per bus write
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_select_left,
  output logic            out_select_right,
  output logic            out_is_data,
  output logic [7:0]      out_bus_byte,
  output logic            out_last
);
  import gcws_pkg::*;

  cfg_t cfg_r;
  logic q_full;
  logic q_push;
  job_t q_job;
  logic q_pop;
  logic head_valid;
  job_t head_job;

  // Command base registers; reset to the controller's native set-page / set-column codes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.page_base <= 8'd184;
      cfg_r.col_base  <= 8'd64;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAGE_BASE: cfg_r.page_base <= cfg_data;
        REG_COL_BASE:  cfg_r.col_base  <= cfg_data;
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  // Front end: cursor tracking and job expansion
  gcws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_value  (in_value),
    .in_target (in_target),
    .in_page   (in_page),
    .in_column (in_column),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // Job queue decouples the two sides
  gcws_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back end: one bus write per cycle while out_stall is low, into the output register
  gcws_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_select_left  (out_select_left),
    .out_select_right (out_select_right),
    .out_is_data      (out_is_data),
    .out_bus_byte     (out_bus_byte),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  // writes of one job leave without gaps: the job stays at the queue head until its last write
  a_job_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("bus write sequence broken before last write");

  // nothing can appear at the output without a queued job
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!head_valid && !out_valid) |=> !out_valid)
    else $error("output transaction without a queued job");

  // an accepted goto always lands in the queue
  a_goto_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_opcode == OP_GOTO)) |=> head_valid)
    else $error("accepted goto not queued");
`endif

endmodule

`default_nettype wire

/* design/gcws_front.sv */
// Front end: accepts items, tracks the cursor and expands each item into a job.
`default_nettype none

module gcws_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire gcws_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    in_opcode,
  input  wire logic [7:0]    in_value,
  input  wire logic [1:0]    in_target,
  input  wire logic [7:0]    in_page,
  input  wire logic [7:0]    in_column,
  input  wire logic          q_full,
  output logic               q_push,
  output gcws_pkg::job_t     q_job
);
  import gcws_pkg::*;

  logic [2:0] cursor_page_r, cursor_page_nxt;
  logic [6:0] cursor_col_r, cursor_col_nxt;
  logic       accept;
  opcode_t    op;
  logic [2:0] pg_c;
  logic [6:0] col_c;
  logic [2:0] pg_inc;
  logic       half_cross;
  logic [1:0] data_sel;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign op       = opcode_t'(in_opcode);
  assign q_push   = accept && (op != OP_RSVD);

  assign pg_c   = (in_page > PAGE_LIMIT) ? PAGE_MAX : in_page[2:0];
  assign col_c  = (in_column > COL_LIMIT) ? COL_LAST : in_column[6:0];
  assign pg_inc = cursor_page_r + 3'd1;

  // single-half data write: right half is forced past column 63
  assign half_cross = (in_target != SEL_BOTH) && (cursor_col_r == COL_HALF);
  assign data_sel   = ((in_target != SEL_BOTH) && cursor_col_r[6]) ? SEL_RIGHT : in_target;

  always_comb begin
    q_job           = '0;
    cursor_page_nxt = cursor_page_r;
    cursor_col_nxt  = cursor_col_r;
    case (op)
      OP_GOTO: begin
        q_job.count = 2'd2;
        q_job.wr[0] = mk_write(col_c[6] ? SEL_RIGHT : SEL_LEFT, 1'b0,
                               cfg.page_base + {5'd0, pg_c});
        q_job.wr[1] = mk_write(col_c[6] ? SEL_RIGHT : SEL_LEFT, 1'b0,
                               cfg.col_base + {2'd0, col_c[5:0]});
        cursor_page_nxt = pg_c;
        cursor_col_nxt  = col_c;
      end
      OP_CMD: begin
        q_job.count = 2'd1;
        q_job.wr[0] = mk_write(in_target, 1'b0, in_value);
      end
      OP_DATA: begin
        if (half_cross) begin
          q_job.count = 2'd3;
          q_job.wr[0] = mk_write(SEL_RIGHT, 1'b0, cfg.page_base + {5'd0, cursor_page_r});
          q_job.wr[1] = mk_write(SEL_RIGHT, 1'b0, cfg.col_base);
          q_job.wr[2] = mk_write(data_sel, 1'b1, in_value);
        end else if (cursor_col_r == COL_LAST) begin
          q_job.count = 2'd3;
          q_job.wr[0] = mk_write(data_sel, 1'b1, in_value);
          q_job.wr[1] = mk_write(SEL_LEFT, 1'b0, cfg.page_base + {5'd0, pg_inc});
          q_job.wr[2] = mk_write(SEL_LEFT, 1'b0, cfg.col_base);
        end else begin
          q_job.count = 2'd1;
          q_job.wr[0] = mk_write(data_sel, 1'b1, in_value);
        end
        if (cursor_col_r == COL_LAST) begin
          cursor_col_nxt  = '0;
          cursor_page_nxt = pg_inc;
        end else begin
          cursor_col_nxt = cursor_col_r + 7'd1;
        end
      end
      default: begin
        q_job = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_page_r <= '0;
      cursor_col_r  <= '0;
    end else if (q_push) begin
      cursor_page_r <= cursor_page_nxt;
      cursor_col_r  <= cursor_col_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/gcws_fifo.sv */
// Short job queue between the front end and the bus sequencer.
`default_nettype none

module gcws_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire gcws_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                head_valid,
  output gcws_pkg::job_t      head_job
);
  import gcws_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/gcws_back.sv */
// Back end: issues the bus writes of the head job, one per cycle while out_stall is low, into an output register.
`default_nettype none

module gcws_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           head_valid,
  input  wire gcws_pkg::job_t head_job,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                out_select_left,
  output logic                out_select_right,
  output logic                out_is_data,
  output logic [7:0]          out_bus_byte,
  output logic                out_last
);
  import gcws_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  bus_write_t wr_r;
  logic       last_r;
  logic       load;
  logic       is_last;
  bus_write_t cur;

  assign load    = head_valid && (!out_valid_r || !out_stall);
  assign cur     = head_job.wr[idx_r];
  assign is_last = (idx_r == head_job.count - 2'd1);
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = is_last ? '0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      wr_r   <= cur;
      last_r <= is_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_select_left  = wr_r.sel[0];
  assign out_select_right = wr_r.sel[1];
  assign out_is_data      = wr_r.is_data;
  assign out_bus_byte     = wr_r.bus_byte;
  assign out_last         = last_r;

endmodule

`default_nettype wire
